>>> rtl/core/qds_pkg.sv
// Shared types, constants, microprogram and arithmetic helpers for the dynamics step core.
`timescale 1ns / 1ps
package qds_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int TS_W   = 17;
  localparam int NREG   = 32;
  localparam int PC_W   = 7;

  localparam logic [TS_W-1:0] TS_RESET = 17'd655;

  typedef struct packed {
    logic signed [WORD_W-1:0] cmd_roll;
    logic signed [WORD_W-1:0] cmd_pitch;
    logic signed [WORD_W-1:0] cmd_yaw;
    logic signed [WORD_W-1:0] cmd_thrust;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] angle_roll;
    logic signed [WORD_W-1:0] angle_pitch;
    logic signed [WORD_W-1:0] angle_yaw;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
  } out_item_t;

  // Micro-operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_SC  = 3'd3;
  localparam logic [2:0] OP_OUT = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] dst;
    logic [5:0] a;
    logic [5:0] b;
  } uop_t;

  // Register file addresses (also operand codes below 32)
  localparam logic [5:0] R_W0 = 6'd0,  R_W1 = 6'd1,  R_W2 = 6'd2;
  localparam logic [5:0] R_A0 = 6'd3,  R_A1 = 6'd4,  R_A2 = 6'd5;
  localparam logic [5:0] R_V0 = 6'd6,  R_V1 = 6'd7,  R_V2 = 6'd8;
  localparam logic [5:0] R_P0 = 6'd9,  R_P1 = 6'd10, R_P2 = 6'd11;
  localparam logic [5:0] R_U0 = 6'd12, R_U1 = 6'd13, R_U2 = 6'd14, R_U3 = 6'd15;
  localparam logic [5:0] R_L0 = 6'd16, R_L1 = 6'd17, R_L2 = 6'd18;
  localparam logic [5:0] R_S0 = 6'd19, R_S1 = 6'd20, R_S2 = 6'd21;
  localparam logic [5:0] R_C0 = 6'd22, R_C1 = 6'd23, R_C2 = 6'd24;
  localparam logic [5:0] R_T0 = 6'd25, R_T1 = 6'd26;

  // Non-register operand codes
  localparam logic [5:0] SRC_IN0 = 6'd32, SRC_IN1 = 6'd33, SRC_IN2 = 6'd34;
  localparam logic [5:0] SRC_IN3 = 6'd35, SRC_DT  = 6'd36;
  localparam logic [5:0] K_12  = 6'd37, K_8   = 6'd38, K_10 = 6'd39;
  localparam logic [5:0] K_0P9 = 6'd40, K_0P2 = 6'd41, K_0P5 = 6'd42;
  localparam logic [5:0] K_0P1 = 6'd43, K_KT  = 6'd44, K_NKT = 6'd45;
  localparam logic [5:0] K_G   = 6'd46, K_5   = 6'd47, K_0   = 6'd48, K_6 = 6'd49;

  // Output slots
  localparam logic [5:0] O_ROLL = 6'd0, O_PITCH = 6'd1, O_YAW = 6'd2;
  localparam logic [5:0] O_PX   = 6'd3, O_PY    = 6'd4, O_PZ  = 6'd5;

  localparam logic [PC_W-1:0] PROG_LAST = 7'd65;

  // CORDIC constants
  localparam int CORDIC_ITER = 24;
  localparam logic [19:0] TWO_PI_Q = 20'd411775;
  localparam logic signed [20:0] TWO_PI_R = 21'sd411775;
  localparam logic signed [20:0] PI_R = 21'sd205887;
  localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic            load_in;
    logic            rd;
    logic            ex;
    logic            wb;
    logic            wb_cos;
    logic            publish;
    logic [PC_W-1:0] pc;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic out_free;
  } sts_t;

  function automatic uop_t mk(input logic [2:0] op, input logic [5:0] dst,
                              input logic [5:0] a, input logic [5:0] b);
    uop_t u;
    u.op = op;
    u.dst = dst[4:0];
    u.a = a;
    u.b = b;
    return u;
  endfunction

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      // effective inputs
      7'd0:  u = mk(OP_ADD, R_U0, SRC_IN0, K_5);
      7'd1:  u = mk(OP_ADD, R_U1, SRC_IN1, K_10);
      7'd2:  u = mk(OP_ADD, R_U2, SRC_IN2, K_0);
      7'd3:  u = mk(OP_ADD, R_U3, SRC_IN3, K_6);
      // roll acceleration
      7'd4:  u = mk(OP_MUL, R_T0, K_0P9, R_W1);
      7'd5:  u = mk(OP_MUL, R_T0, R_T0, R_W2);
      7'd6:  u = mk(OP_MUL, R_T1, K_12, R_U0);
      7'd7:  u = mk(OP_SUB, R_T1, R_T1, R_T0);
      7'd8:  u = mk(OP_ADD, R_L0, R_T1, K_0P1);
      // pitch acceleration
      7'd9:  u = mk(OP_MUL, R_T0, K_0P2, R_W0);
      7'd10: u = mk(OP_MUL, R_T0, R_T0, R_W2);
      7'd11: u = mk(OP_MUL, R_T1, K_8, R_U1);
      7'd12: u = mk(OP_ADD, R_L1, R_T1, R_T0);
      // yaw acceleration
      7'd13: u = mk(OP_MUL, R_T0, K_0P5, R_W1);
      7'd14: u = mk(OP_MUL, R_T0, R_T0, R_W0);
      7'd15: u = mk(OP_MUL, R_T1, K_10, R_U2);
      7'd16: u = mk(OP_SUB, R_L2, R_T1, R_T0);
      // rates
      7'd17: u = mk(OP_MUL, R_T0, R_L0, SRC_DT);
      7'd18: u = mk(OP_ADD, R_W0, R_W0, R_T0);
      7'd19: u = mk(OP_MUL, R_T0, R_L1, SRC_DT);
      7'd20: u = mk(OP_ADD, R_W1, R_W1, R_T0);
      7'd21: u = mk(OP_MUL, R_T0, R_L2, SRC_DT);
      7'd22: u = mk(OP_ADD, R_W2, R_W2, R_T0);
      // angles
      7'd23: u = mk(OP_MUL, R_T0, R_W0, SRC_DT);
      7'd24: u = mk(OP_ADD, R_A0, R_A0, R_T0);
      7'd25: u = mk(OP_MUL, R_T0, R_W1, SRC_DT);
      7'd26: u = mk(OP_ADD, R_A1, R_A1, R_T0);
      7'd27: u = mk(OP_MUL, R_T0, R_W2, SRC_DT);
      7'd28: u = mk(OP_ADD, R_A2, R_A2, R_T0);
      // sine and cosine, cosine lands three entries up
      7'd29: u = mk(OP_SC, R_S0, R_A0, R_A0);
      7'd30: u = mk(OP_SC, R_S1, R_A1, R_A1);
      7'd31: u = mk(OP_SC, R_S2, R_A2, R_A2);
      // x acceleration
      7'd32: u = mk(OP_MUL, R_T0, R_S0, R_S2);
      7'd33: u = mk(OP_MUL, R_T1, R_C0, R_C2);
      7'd34: u = mk(OP_MUL, R_T1, R_T1, R_S1);
      7'd35: u = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd36: u = mk(OP_MUL, R_T0, K_KT, R_T0);
      7'd37: u = mk(OP_MUL, R_L0, R_T0, R_U3);
      // y acceleration
      7'd38: u = mk(OP_MUL, R_T0, R_C2, R_S0);
      7'd39: u = mk(OP_MUL, R_T1, R_C0, R_S1);
      7'd40: u = mk(OP_MUL, R_T1, R_T1, R_S2);
      7'd41: u = mk(OP_SUB, R_T0, R_T0, R_T1);
      7'd42: u = mk(OP_MUL, R_T0, K_NKT, R_T0);
      7'd43: u = mk(OP_MUL, R_L1, R_T0, R_U3);
      // z acceleration
      7'd44: u = mk(OP_MUL, R_T0, K_KT, R_C1);
      7'd45: u = mk(OP_MUL, R_T0, R_T0, R_C0);
      7'd46: u = mk(OP_MUL, R_T0, R_T0, R_U3);
      7'd47: u = mk(OP_SUB, R_L2, R_T0, K_G);
      // velocities
      7'd48: u = mk(OP_MUL, R_T0, R_L0, SRC_DT);
      7'd49: u = mk(OP_ADD, R_V0, R_V0, R_T0);
      7'd50: u = mk(OP_MUL, R_T0, R_L1, SRC_DT);
      7'd51: u = mk(OP_ADD, R_V1, R_V1, R_T0);
      7'd52: u = mk(OP_MUL, R_T0, R_L2, SRC_DT);
      7'd53: u = mk(OP_ADD, R_V2, R_V2, R_T0);
      // positions
      7'd54: u = mk(OP_MUL, R_T0, R_V0, SRC_DT);
      7'd55: u = mk(OP_ADD, R_P0, R_P0, R_T0);
      7'd56: u = mk(OP_MUL, R_T0, R_V1, SRC_DT);
      7'd57: u = mk(OP_ADD, R_P1, R_P1, R_T0);
      7'd58: u = mk(OP_MUL, R_T0, R_V2, SRC_DT);
      7'd59: u = mk(OP_ADD, R_P2, R_P2, R_T0);
      // result staging
      7'd60: u = mk(OP_OUT, O_ROLL, R_A0, R_A0);
      7'd61: u = mk(OP_OUT, O_PITCH, R_A1, R_A1);
      7'd62: u = mk(OP_OUT, O_YAW, R_A2, R_A2);
      7'd63: u = mk(OP_OUT, O_PX, R_P0, R_P0);
      7'd64: u = mk(OP_OUT, O_PY, R_P1, R_P1);
      7'd65: u = mk(OP_OUT, O_PZ, R_P2, R_P2);
      default: u = mk(OP_OUT, O_ROLL, R_A0, R_A0);
    endcase
    return u;
  endfunction

  function automatic logic signed [WORD_W-1:0] const_val(input logic [5:0] code);
    logic signed [WORD_W-1:0] v;
    unique case (code)
      K_12:    v = 32'sd786432;
      K_8:     v = 32'sd524288;
      K_10:    v = 32'sd655360;
      K_0P9:   v = 32'sd58982;
      K_0P2:   v = 32'sd13107;
      K_0P5:   v = 32'sd32768;
      K_0P1:   v = 32'sd6554;
      K_KT:    v = 32'sd8454;
      K_NKT:   v = -32'sd8454;
      K_G:     v = 32'sd642253;
      K_5:     v = 32'sd327680;
      K_6:     v = 32'sd393216;
      default: v = '0;
    endcase
    return v;
  endfunction

  localparam logic signed [WORD_W:0] SUM_MAX = 33'sd2147483647;
  localparam logic signed [WORD_W:0] SUM_MIN = -33'sd2147483648;
  localparam logic signed [63:0] PROD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] PROD_MIN = -64'sd2147483648;

  function automatic logic signed [WORD_W-1:0] sat_addsub(input logic signed [WORD_W-1:0] a,
                                                          input logic signed [WORD_W-1:0] b,
                                                          input logic sub);
    logic signed [WORD_W:0] s;
    s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
    if (s > SUM_MAX) return SUM_MAX[WORD_W-1:0];
    if (s < SUM_MIN) return SUM_MIN[WORD_W-1:0];
    return s[WORD_W-1:0];
  endfunction

  // Floor-shift the full product back to the word, clamp at the rails
  function automatic logic signed [WORD_W-1:0] sat_prod(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p >>> FRAC_W;
    if (q > PROD_MAX) return PROD_MAX[WORD_W-1:0];
    if (q < PROD_MIN) return PROD_MIN[WORD_W-1:0];
    return q[WORD_W-1:0];
  endfunction

  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    logic signed [34:0] v;
    case (i)
      5'd0:  v = 35'sd843314856;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043836;
      5'd3:  v = 35'sd133525158;
      5'd4:  v = 35'sd67021686;
      5'd5:  v = 35'sd33543515;
      5'd6:  v = 35'sd16775850;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194282;
      5'd9:  v = 35'sd2097149;
      5'd10: v = 35'sd1048575;
      5'd11: v = 35'sd524287;
      5'd12: v = 35'sd262143;
      5'd13: v = 35'sd131071;
      5'd14: v = 35'sd65535;
      5'd15: v = 35'sd32767;
      5'd16: v = 35'sd16383;
      5'd17: v = 35'sd8191;
      5'd18: v = 35'sd4095;
      5'd19: v = 35'sd2047;
      5'd20: v = 35'sd1023;
      5'd21: v = 35'sd511;
      5'd22: v = 35'sd255;
      5'd23: v = 35'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/qds_cordic.sv
// Sine/cosine unit: reciprocal-multiply range reduction followed by iterative CORDIC rotation.
`timescale 1ns / 1ps
module qds_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [qds_pkg::WORD_W-1:0] ang,
  output logic                            done,
  output logic signed [qds_pkg::WORD_W-1:0] sin_o,
  output logic signed [qds_pkg::WORD_W-1:0] cos_o
);
  import qds_pkg::*;

  localparam logic [2:0] CS_IDLE = 3'd0;
  localparam logic [2:0] CS_MUL  = 3'd1;
  localparam logic [2:0] CS_SUB  = 3'd2;
  localparam logic [2:0] CS_FIX  = 3'd3;
  localparam logic [2:0] CS_RED  = 3'd4;
  localparam logic [2:0] CS_ITER = 3'd5;
  localparam logic [2:0] CS_DONE = 3'd6;

  // floor(2^48 / TWO_PI_Q), with 2pi in Q16.16; the quotient estimate is then exact or one low
  localparam logic [63:0] RECIP_FULL = (64'd1 << 48) / {44'd0, TWO_PI_Q};
  localparam logic [29:0] RECIP      = RECIP_FULL[29:0];

  logic [2:0]         cst;
  logic [WORD_W-1:0]  mag;
  logic               neg;
  logic [61:0]        qprod;
  logic [19:0]        rem_raw;
  logic [18:0]        rem;
  logic [4:0]         cnt;
  logic signed [33:0] x, y;
  logic signed [34:0] z;
  logic               flip;

  logic [13:0]        quo;
  logic [32:0]        rem_w;
  logic [19:0]        rem_fx;
  logic signed [20:0] r0, r1;
  logic signed [34:0] z0, z1;
  logic               flip1;
  logic signed [33:0] dx, dy, xs, ys;

  always_comb begin
    quo    = qprod[61:48];
    rem_w  = {1'b0, mag} - (33'(quo) * 33'(TWO_PI_Q));
    rem_fx = (rem_raw >= TWO_PI_Q) ? (rem_raw - TWO_PI_Q) : rem_raw;
  end

  // Remainder takes the dividend's sign, then fold into [-pi, pi] and [-pi/2, pi/2]
  always_comb begin
    r0 = neg ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
    if (r0 >= PI_R) r1 = r0 - TWO_PI_R;
    else if (r0 < -PI_R) r1 = r0 + TWO_PI_R;
    else r1 = r0;
    z0 = 35'(r1) <<< (30 - FRAC_W);
    flip1 = 1'b0;
    z1 = z0;
    if (z0 > HALF_PI_Q30) begin
      z1 = z0 - PI_Q30;
      flip1 = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      z1 = z0 + PI_Q30;
      flip1 = 1'b1;
    end
  end

  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    xs = x >>> (30 - FRAC_W);
    ys = y >>> (30 - FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= CS_IDLE;
    end else if (start) begin
      cst <= CS_MUL;
    end else begin
      unique case (cst)
        CS_IDLE: cst <= CS_IDLE;
        CS_MUL:  cst <= CS_SUB;
        CS_SUB:  cst <= CS_FIX;
        CS_FIX:  cst <= CS_RED;
        CS_RED:  cst <= CS_ITER;
        CS_ITER: if (cnt == 5'(CORDIC_ITER - 1)) cst <= CS_DONE;
        CS_DONE: cst <= CS_DONE;
        default: cst <= CS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= ang[WORD_W-1];
      mag <= ang[WORD_W-1] ? (WORD_W'(0) - ang) : ang;
    end else begin
      case (cst)
        CS_MUL: begin
          qprod <= 62'(mag) * 62'(RECIP);
        end
        CS_SUB: begin
          rem_raw <= rem_w[19:0];
        end
        CS_FIX: begin
          rem <= rem_fx[18:0];
        end
        CS_RED: begin
          x    <= CORDIC_GAIN;
          y    <= '0;
          z    <= z1;
          flip <= flip1;
          cnt  <= '0;
        end
        CS_ITER: begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - atan_q30(cnt);
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + atan_q30(cnt);
          end
          cnt <= cnt + 5'd1;
        end
        default: ;
      endcase
    end
  end

  assign done  = (cst == CS_DONE);
  assign cos_o = flip ? WORD_W'(-xs) : WORD_W'(xs);
  assign sin_o = flip ? WORD_W'(-ys) : WORD_W'(ys);

endmodule

>>> rtl/core/qds_datapath.sv
// Datapath: register file, shared multiplier and adder, CORDIC unit and result register.
`timescale 1ns / 1ps
module qds_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [qds_pkg::TS_W-1:0]     cfg_wdata,
  input  qds_pkg::in_item_t            in_data,
  input  qds_pkg::cmd_t                cmd,
  output qds_pkg::sts_t                sts,
  input  logic                         out_stall,
  output logic                         out_valid,
  output qds_pkg::out_item_t           out_data
);
  import qds_pkg::*;

  logic [TS_W-1:0]          time_step;
  in_item_t                 item;
  logic signed [WORD_W-1:0] mem [NREG];
  logic [NREG-1:0]          vld;
  logic signed [WORD_W-1:0] rda, rdb;
  logic                     rda_v, rdb_v;
  logic signed [WORD_W-1:0] opa, opb;
  logic signed [63:0]       prod;
  logic signed [WORD_W-1:0] alu;
  logic signed [WORD_W-1:0] wdata;
  logic [4:0]               waddr;
  logic                     we;
  out_item_t                stage;
  uop_t                     uop;
  logic                     cdone;
  logic signed [WORD_W-1:0] csin, ccos;

  assign uop = uop_rom(cmd.pc);

  function automatic logic signed [WORD_W-1:0] operand(input logic [5:0] code,
                                                       input logic signed [WORD_W-1:0] rd,
                                                       input logic rv,
                                                       input in_item_t it,
                                                       input logic [TS_W-1:0] ts);
    logic signed [WORD_W-1:0] v;
    if (!code[5]) begin
      v = rv ? rd : '0;
    end else begin
      case (code)
        SRC_IN0: v = it.cmd_roll;
        SRC_IN1: v = it.cmd_pitch;
        SRC_IN2: v = it.cmd_yaw;
        SRC_IN3: v = it.cmd_thrust;
        SRC_DT:  v = $signed({{(WORD_W-TS_W){1'b0}}, ts});
        default: v = const_val(code);
      endcase
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) time_step <= TS_RESET;
    else if (cfg_we) time_step <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) item <= in_data;
  end

  // Register file: two registered read ports, one write port
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rda   <= mem[uop.a[4:0]];
      rdb   <= mem[uop.b[4:0]];
      rda_v <= vld[uop.a[4:0]];
      rdb_v <= vld[uop.b[4:0]];
    end
    if (we) mem[waddr] <= wdata;
  end

  // Entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (we) vld[waddr] <= 1'b1;
  end

  always_comb begin
    opa = operand(uop.a, rda, rda_v, item, time_step);
    opb = operand(uop.b, rdb, rdb_v, item, time_step);
  end

  always_ff @(posedge clk) begin
    if (cmd.ex) begin
      prod <= opa * opb;
      case (uop.op)
        OP_ADD:  alu <= sat_addsub(opa, opb, 1'b0);
        OP_SUB:  alu <= sat_addsub(opa, opb, 1'b1);
        default: alu <= opa;
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = uop.dst;
    wdata = alu;
    if (cmd.wb_cos) begin
      we    = 1'b1;
      waddr = uop.dst + 5'd3;
      wdata = ccos;
    end else if (cmd.wb && uop.op != OP_OUT) begin
      we = 1'b1;
      case (uop.op)
        OP_MUL:  wdata = sat_prod(prod);
        OP_SC:   wdata = csin;
        default: wdata = alu;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb && uop.op == OP_OUT) begin
      case ({1'b0, uop.dst})
        O_ROLL:  stage.angle_roll  <= alu;
        O_PITCH: stage.angle_pitch <= alu;
        O_YAW:   stage.angle_yaw   <= alu;
        O_PX:    stage.pos_x       <= alu;
        O_PY:    stage.pos_y       <= alu;
        default: stage.pos_z       <= alu;
      endcase
    end
  end

  qds_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.ex && uop.op == OP_SC),
    .ang   (opa),
    .done  (cdone),
    .sin_o (csin),
    .cos_o (ccos)
  );

  // Result register parts the compute side from the output channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) out_data <= stage;
  end

  assign sts.cordic_done = cdone;
  assign sts.out_free    = !out_valid || !out_stall;

endmodule

>>> rtl/core/qds_ctrl.sv
// Controller: steps the microprogram, one read / execute / write-back sequence per operation.
`timescale 1ns / 1ps
module qds_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  qds_pkg::sts_t sts,
  output qds_pkg::cmd_t cmd
);
  import qds_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_CW   = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_WB2  = 3'd5;
  localparam logic [2:0] S_PUB  = 3'd6;

  logic [2:0]      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  uop_t            cur_uop;
  logic            is_sc;

  assign cur_uop  = uop_rom(pc);
  assign is_sc    = (cur_uop.op == OP_SC);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    pc_next     = pc;
    cmd         = '0;
    cmd.pc      = pc;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pc_next     = '0;
          state_next  = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_EX;
      end
      S_EX: begin
        cmd.ex     = 1'b1;
        state_next = is_sc ? S_CW : S_WB;
      end
      S_CW: begin
        if (sts.cordic_done) state_next = S_WB;
      end
      S_WB, S_WB2: begin
        if (state == S_WB) cmd.wb = 1'b1;
        else cmd.wb_cos = 1'b1;
        if (state == S_WB && is_sc) begin
          state_next = S_WB2;
        end else if (pc == PROG_LAST) begin
          state_next = S_PUB;
        end else begin
          pc_next    = pc + 7'd1;
          state_next = S_RD;
        end
      end
      S_PUB: begin
        // hold the staged result until the output register frees up
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

endmodule

>>> rtl/core/quadrotor_dynamics_step_core.sv
// Each item runs the microprogram: 63 plain operations, each a read, execute and write-back
// on the shared multiplier/adder, and three sine/cosine operations, each a reciprocal-multiply
// angle reduction (multiply, subtract, fix, reduce) and 24 CORDIC iterations, plus publish.
// Items are taken one at a time, the next once the result is published, even while it waits; a
// stalled result holds the core in publish until the output register frees up.
// Reset: synchronous, clears rates, angles, velocities and positions, loads time_step 655.
`timescale 1ns / 1ps
module quadrotor_dynamics_step_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [qds_pkg::TS_W-1:0]  cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  qds_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output qds_pkg::out_item_t        out_data
);
  import qds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  qds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  qds_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/qds_checker.sv
// Port-level checker for the dynamics step core and its bind.
`timescale 1ns / 1ps
module qds_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_we,
  input logic [qds_pkg::TS_W-1:0] cfg_wdata,
  input logic                     in_valid,
  input logic                     in_stall,
  input qds_pkg::in_item_t        in_data,
  input logic                     out_valid,
  input logic                     out_stall,
  input qds_pkg::out_item_t       out_data
);
  import qds_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the step finished");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quadrotor_dynamics_step_core qds_checker u_qds_checker (.*);
